// ===== design/mlpf_pkg.sv =====
// ---------------------------------------------------------------------------
// Monochrome page framebuffer package
// Shared types, operation codes and panel command constants.
// ---------------------------------------------------------------------------
`default_nettype none

package mlpf_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int PAGE_W = 3;

  localparam logic [1:0] OP_SET_AREA = 2'd0;
  localparam logic [1:0] OP_FILL     = 2'd1;
  localparam logic [1:0] OP_PIXEL    = 2'd2;
  localparam logic [1:0] OP_PULL     = 2'd3;

  localparam logic [7:0] CMD_PAGE      = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] CMD_RMW_START = 8'hE0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_PULL_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_PAGE,
    PH_COL_LO,
    PH_COL_HI,
    PH_RMW_START,
    PH_DATA
  } phase_e;

  typedef struct packed {
    logic set_area;
    logic fill_start;
    logic pixel_step;
    logic pull_rd;
    logic clear_step;
    logic fill_rd;
    logic fill_wr;
    logic pix_wr;
    logic pull_out;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic visible;
    logic pix_on;
    logic fill_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/mlpf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Monochrome page framebuffer controller
// Sequences clearing, fill walks, pixel updates and flush byte requests.
// ---------------------------------------------------------------------------
`default_nettype none

module mlpf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [1:0]       op_i,
  input  wire mlpf_pkg::status_t status_i,
  output mlpf_pkg::cmd_t        cmd_o
);

  mlpf_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlpf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlpf_pkg::ST_CLEAR: begin
        if (!status_i.clearing) state_d = mlpf_pkg::ST_IDLE;
      end
      mlpf_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            mlpf_pkg::OP_FILL: begin
              if (status_i.visible) state_d = mlpf_pkg::ST_FILL_RD;
            end
            mlpf_pkg::OP_PIXEL: begin
              if (status_i.visible && status_i.pix_on) state_d = mlpf_pkg::ST_PIX_WR;
            end
            mlpf_pkg::OP_PULL: state_d = mlpf_pkg::ST_PULL_OUT;
            default: state_d = mlpf_pkg::ST_IDLE;
          endcase
        end
      end
      mlpf_pkg::ST_PIX_WR:  state_d = mlpf_pkg::ST_IDLE;
      mlpf_pkg::ST_FILL_RD: state_d = mlpf_pkg::ST_FILL_WR;
      mlpf_pkg::ST_FILL_WR: begin
        state_d = status_i.fill_done ? mlpf_pkg::ST_IDLE : mlpf_pkg::ST_FILL_RD;
      end
      mlpf_pkg::ST_PULL_OUT: begin
        if (status_i.out_free) state_d = mlpf_pkg::ST_IDLE;
      end
      default: state_d = mlpf_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      mlpf_pkg::ST_CLEAR: cmd_o.clear_step = status_i.clearing;
      mlpf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.set_area   = accept && (op_i == mlpf_pkg::OP_SET_AREA);
        cmd_o.fill_start = accept && (op_i == mlpf_pkg::OP_FILL) && status_i.visible;
        cmd_o.pixel_step = accept && (op_i == mlpf_pkg::OP_PIXEL) && status_i.visible;
        cmd_o.pull_rd    = accept && (op_i == mlpf_pkg::OP_PULL);
      end
      mlpf_pkg::ST_PIX_WR:   cmd_o.pix_wr = 1'b1;
      mlpf_pkg::ST_FILL_RD:  cmd_o.fill_rd = 1'b1;
      mlpf_pkg::ST_FILL_WR:  cmd_o.fill_wr = 1'b1;
      mlpf_pkg::ST_PULL_OUT: cmd_o.pull_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mlpf_datapath.sv =====
// ---------------------------------------------------------------------------
// Monochrome page framebuffer datapath
// Frame store, area and stream registers, flush sequencer and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mlpf_datapath #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [71:0]       s_axis_tdata,
  input  wire mlpf_pkg::cmd_t    cmd_i,
  output mlpf_pkg::status_t      status_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic [1:0]             m_axis_tuser
);

  localparam int DEPTH = COLUMNS * ROWS / 8;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [15:0] XMAX = 16'(COLUMNS - 1);
  localparam logic signed [15:0] YMAX = 16'(ROWS - 1);

  localparam int CW = mlpf_pkg::COL_W;
  localparam int RW = mlpf_pkg::ROW_W;
  localparam int PW = mlpf_pkg::PAGE_W;

  logic signed [15:0] in_left, in_top, in_right, in_bottom;
  logic               in_color;

  logic signed [15:0] area_left_q, area_top_q, area_right_q, area_bottom_q;
  logic signed [15:0] pix_col_q, pix_row_q, pix_col_d, pix_row_d;
  logic               pix_last;

  logic               flush_pending_q;
  logic [PW-1:0]      flush_page_q;
  logic [CW-1:0]      flush_col_q;
  mlpf_pkg::phase_e   flush_phase_q;
  logic [CW-1:0]      bnd_x1_q, bnd_x2_q;
  logic [PW-1:0]      bnd_p2_q;

  logic [PW-1:0]      fill_page_q;
  logic [CW-1:0]      fill_col_q;
  logic [RW-1:0]      fill_y1_q, fill_y2_q;
  logic               fill_color_q;
  logic [7:0]         fill_mask;

  logic [AW-1:0]      pix_addr_q;
  logic [7:0]         pix_bit_q;
  logic               pix_color_q;

  logic               clr_busy_q;
  logic [AW-1:0]      clr_cnt_q;

  logic               visible, pix_on, arm;
  logic [CW-1:0]      cx1, cx2;
  logic [RW-1:0]      cy1, cy2;

  logic [7:0]         mem [DEPTH];
  logic [7:0]         rdata_q;
  logic [AW-1:0]      rd_addr, wr_addr, pix_addr, flush_addr, fill_addr;
  logic               we;
  logic [7:0]         wdata;

  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_data_q, out_last_q, out_idle_q;
  logic               out_free;

  assign in_left   = s_axis_tdata[15:0];
  assign in_top    = s_axis_tdata[31:16];
  assign in_right  = s_axis_tdata[47:32];
  assign in_bottom = s_axis_tdata[63:48];
  assign in_color  = s_axis_tdata[64];

  assign visible = !(area_right_q < 0 || area_bottom_q < 0 ||
                     area_left_q > XMAX || area_top_q > YMAX ||
                     area_right_q < area_left_q || area_bottom_q < area_top_q);
  assign cx1 = (area_left_q < 0) ? '0 : area_left_q[CW-1:0];
  assign cy1 = (area_top_q < 0) ? '0 : area_top_q[RW-1:0];
  assign cx2 = (area_right_q > XMAX) ? XMAX[CW-1:0] : area_right_q[CW-1:0];
  assign cy2 = (area_bottom_q > YMAX) ? YMAX[RW-1:0] : area_bottom_q[RW-1:0];

  assign pix_on = pix_col_q >= 0 && pix_col_q <= XMAX && pix_row_q >= 0 && pix_row_q <= YMAX;

  always_comb begin
    pix_col_d = pix_col_q;
    pix_row_d = pix_row_q;
    pix_last  = 1'b0;
    if (pix_col_q < area_right_q) begin
      pix_col_d = pix_col_q + 16'sd1;
    end else begin
      pix_col_d = area_left_q;
      if (pix_row_q < area_bottom_q) begin
        pix_row_d = pix_row_q + 16'sd1;
      end else begin
        pix_row_d = area_top_q;
        pix_last  = 1'b1;
      end
    end
  end

  assign arm = cmd_i.fill_start || (cmd_i.pixel_step && pix_last);

  assign pix_addr   = AW'(32'(pix_row_q[RW-1:3]) * COLUMNS + 32'(pix_col_q[CW-1:0]));
  assign flush_addr = AW'(32'(flush_page_q) * COLUMNS + 32'(flush_col_q));
  assign fill_addr  = AW'(32'(fill_page_q) * COLUMNS + 32'(fill_col_q));

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      fill_mask[7-r] = ({fill_page_q, 3'(r)} >= fill_y1_q) &&
                       ({fill_page_q, 3'(r)} <= fill_y2_q);
    end
  end

  always_comb begin
    if (cmd_i.pixel_step) begin
      rd_addr = pix_addr;
    end else if (cmd_i.fill_rd) begin
      rd_addr = fill_addr;
    end else begin
      rd_addr = flush_addr;
    end
    we      = cmd_i.clear_step || cmd_i.fill_wr || cmd_i.pix_wr;
    wr_addr = clr_cnt_q;
    wdata   = '0;
    if (cmd_i.fill_wr) begin
      wr_addr = fill_addr;
      wdata   = fill_color_q ? (rdata_q | fill_mask) : (rdata_q & ~fill_mask);
    end else if (cmd_i.pix_wr) begin
      wr_addr = pix_addr_q;
      wdata   = pix_color_q ? (rdata_q & ~pix_bit_q) : (rdata_q | pix_bit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (cmd_i.clear_step) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
      else clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= '0;
      area_top_q    <= '0;
      area_right_q  <= '0;
      area_bottom_q <= '0;
      pix_col_q     <= '0;
      pix_row_q     <= '0;
    end else if (cmd_i.set_area) begin
      area_left_q   <= in_left;
      area_top_q    <= in_top;
      area_right_q  <= in_right;
      area_bottom_q <= in_bottom;
      pix_col_q     <= in_left;
      pix_row_q     <= in_top;
    end else if (cmd_i.pixel_step) begin
      pix_col_q <= pix_col_d;
      pix_row_q <= pix_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pixel_step) begin
      pix_addr_q  <= pix_addr;
      pix_bit_q   <= 8'h80 >> pix_row_q[2:0];
      pix_color_q <= in_color;
    end
    if (cmd_i.fill_start) begin
      fill_page_q  <= cy1[RW-1:3];
      fill_col_q   <= cx1;
      fill_y1_q    <= cy1;
      fill_y2_q    <= cy2;
      fill_color_q <= in_color;
    end else if (cmd_i.fill_wr) begin
      if (fill_col_q == bnd_x2_q) begin
        fill_col_q  <= bnd_x1_q;
        fill_page_q <= fill_page_q + 1'b1;
      end else begin
        fill_col_q <= fill_col_q + 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_pending_q <= 1'b0;
      flush_page_q    <= '0;
      flush_col_q     <= '0;
      flush_phase_q   <= mlpf_pkg::PH_PAGE;
      bnd_x1_q        <= '0;
      bnd_x2_q        <= '0;
      bnd_p2_q        <= '0;
    end else if (arm) begin
      flush_pending_q <= 1'b1;
      flush_page_q    <= cy1[RW-1:3];
      flush_col_q     <= cx1;
      flush_phase_q   <= mlpf_pkg::PH_PAGE;
      bnd_x1_q        <= cx1;
      bnd_x2_q        <= cx2;
      bnd_p2_q        <= cy2[RW-1:3];
    end else if (cmd_i.pull_out && flush_pending_q) begin
      case (flush_phase_q)
        mlpf_pkg::PH_PAGE:   flush_phase_q <= mlpf_pkg::PH_COL_LO;
        mlpf_pkg::PH_COL_LO: flush_phase_q <= mlpf_pkg::PH_COL_HI;
        mlpf_pkg::PH_COL_HI: flush_phase_q <= mlpf_pkg::PH_RMW_START;
        mlpf_pkg::PH_RMW_START: begin
          flush_phase_q <= mlpf_pkg::PH_DATA;
          flush_col_q   <= bnd_x1_q;
        end
        default: begin
          if (flush_col_q >= bnd_x2_q) begin
            flush_phase_q <= mlpf_pkg::PH_PAGE;
            flush_col_q   <= bnd_x1_q;
            if (flush_page_q >= bnd_p2_q) flush_pending_q <= 1'b0;
            else flush_page_q <= flush_page_q + 1'b1;
          end else begin
            flush_col_q <= flush_col_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pull_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pull_out) begin
      out_byte_q <= '0;
      out_data_q <= 1'b0;
      out_last_q <= 1'b0;
      out_idle_q <= !flush_pending_q;
      if (flush_pending_q) begin
        case (flush_phase_q)
          mlpf_pkg::PH_PAGE:      out_byte_q <= mlpf_pkg::CMD_PAGE | {5'b00000, ~flush_page_q};
          mlpf_pkg::PH_COL_LO:    out_byte_q <= mlpf_pkg::CMD_COL_LO | 8'(bnd_x1_q[3:0]);
          mlpf_pkg::PH_COL_HI:    out_byte_q <= mlpf_pkg::CMD_COL_HI | 8'(bnd_x1_q[CW-1:4]);
          mlpf_pkg::PH_RMW_START: out_byte_q <= mlpf_pkg::CMD_RMW_START;
          default: begin
            out_byte_q <= rdata_q;
            out_data_q <= 1'b1;
            out_last_q <= (flush_col_q >= bnd_x2_q) && (flush_page_q >= bnd_p2_q);
          end
        endcase
      end
    end
  end

  assign status_o.clearing  = clr_busy_q;
  assign status_o.visible   = visible;
  assign status_o.pix_on    = pix_on;
  assign status_o.fill_done = (fill_col_q == bnd_x2_q) && (fill_page_q == bnd_p2_q);
  assign status_o.out_free  = out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_idle_q, out_data_q};

endmodule

`default_nettype wire

// ===== design/mono_lcd_page_framebuffer_core.sv =====
// ---------------------------------------------------------------------------
// Monochrome page LCD framebuffer core
// Page-organized frame store with area fill, pixel streaming and partial flush.
// ---------------------------------------------------------------------------
// The slave channel carries requests: tuser selects set area, fill, map pixel
// or pull, tdata carries the area corners and the color. The master channel
// returns one byte per pull: tdata is the panel byte, tuser flags data and
// idle, tlast marks the final byte of a flush.
// A set-area request loads the area registers and the pixel position. A pixel
// request reads and writes back one store byte, or neither when the pixel
// lies off screen or the area is not visible. A pull reads through the single
// read port of the frame store; the byte then sits in the output register,
// and the next request is taken while it waits.
// A fill makes one read and one write for each store byte in the clipped area.
// After reset all COLUMNS * ROWS / 8 bytes of the frame store are swept to
// zero, one byte per cycle; no request is accepted until then.
// When the receiver stalls, a pending pull waits until the output register
// frees up, and no further request is taken meanwhile.
`default_nettype none

module mono_lcd_page_framebuffer_core #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // x_left, y_top, x_right, y_bottom, color
  input  wire logic [1:0]  s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser   // is_data, idle
);

  mlpf_pkg::cmd_t    cmd;
  mlpf_pkg::status_t status;

  mlpf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  mlpf_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== design/mlpf_checker.sv =====
// ---------------------------------------------------------------------------
// Monochrome page framebuffer port checker
// Checks output byte coding and output stability on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

module mlpf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [1:0] m_axis_tuser
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled output byte changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'h00 && !m_axis_tlast)
    else $error("Idle answer carries a nonzero byte or end mark.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("Flush ended on a command byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("Byte flagged both as data and as idle.");

endmodule

bind mono_lcd_page_framebuffer_core mlpf_checker u_mlpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
